// ===== rtl/sida_pkg.sv =====
// package for the signed integer to decimal ascii converter: constants, types, helpers
`timescale 1ns / 1ps

package sida_pkg;

    localparam int DEF_VALUE_BITS     = 32;
    localparam int DEF_MAX_PAD_DIGITS = 16;

    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 3;
    localparam int MIN_DIGITS_W = 5;
    localparam int CHAR_W       = 6;
    localparam int M_TDATA_W    = 8;

    // register index, taken from paddr bit 2 (one 32-bit word per register)
    localparam logic REG_MIN_DIGITS = 1'b0;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;
    localparam logic [3:0]        BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0]        BCD_ADJ     = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    // decimal digits needed for the magnitude of a bits-wide two's complement value
    function automatic int bcd_digits(input int bits);
        return (bits * 3) / 10 + 1;
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/signed_int_to_decimal_ascii_top.sv =====
// signed integer to zero-padded decimal ascii text, one character per output item
//
// Usage:
//   s_ channel: one item carries a signed two's complement value in s_tdata.
//   m_ channel: the decimal text, most significant character first, one
//   character per item in m_tdata[5:0]; m_tlast marks the final character.
//   Negative values start with '-'; digits are padded with leading '0' up to
//   min_digits (apb register 0, saturated to MAX_PAD_DIGITS, sign not counted).
// Timing:
//   the block takes one item at a time; s_tready is high only when idle.
//   An item goes through the shift-add-3 binary to bcd loop (one bit per
//   cycle through a single adjust-and-shift unit), then a scan that steps
//   past each skipped leading zero (at most 9 for 32-bit values), then the
//   characters go one by one into the output register while the receiver is
//   ready; the sign or first digit is registered once the scan is done.
// Reset and stalls:
//   aresetn (synchronous, active low) returns to idle, empties the output
//   register and clears min_digits to 0. When m_tready is low the output
//   register holds its character and emission pauses; a new item can be
//   accepted while the last character of the previous one still waits.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_BITS     = sida_pkg::DEF_VALUE_BITS,
    parameter int MAX_PAD_DIGITS = sida_pkg::DEF_MAX_PAD_DIGITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,  // [VALUE_BITS-1:0] value
    // result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sida_pkg::M_TDATA_W-1:0]       m_tdata,   // [5:0] char_code
    output logic                                 m_tlast,   // last_char
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sida_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [sida_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [sida_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import sida_pkg::*;

    localparam int BCD_DIGITS = bcd_digits(VALUE_BITS);
    localparam int BCD_IDX_W  = $clog2(BCD_DIGITS);
    localparam int LEN        = max_int(BCD_DIGITS, MAX_PAD_DIGITS);
    localparam int IDX_W      = $clog2(LEN);
    localparam int PAD_W      = $clog2(MAX_PAD_DIGITS + 1);
    localparam int CW         = max_int(IDX_W, PAD_W) + 1;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    state_t state_reg, state_next;

    logic [MIN_DIGITS_W-1:0]           min_digits_reg;
    logic [VALUE_BITS-1:0]             bin_reg, bin_next;
    logic [BCD_DIGITS-1:0][3:0]        bcd_reg, bcd_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic                              neg_reg, neg_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]                 char_reg, char_next;
    logic                              last_reg, last_next;

    logic                              s_accept;
    logic                              out_free;
    logic [VALUE_BITS-1:0]             in_value;
    logic                              in_neg;
    logic [BCD_DIGITS-1:0][3:0]        bcd_adj;
    logic [PAD_W-1:0]                  pad_eff;
    logic [IDX_W-1:0]                  idx_start;
    logic [3:0]                        cur_digit;
    logic                              skip_zero;
    logic                              cfg_write;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MIN_DIGITS);
    assign prdata    = (paddr[2] == REG_MIN_DIGITS)
                     ? CFG_DATA_W'(min_digits_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_digits_reg <= '0;
        end else if (cfg_write) begin
            min_digits_reg <= pwdata[MIN_DIGITS_W-1:0];
        end
    end

    // ---------------- shared datapath pieces ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign in_neg   = in_value[VALUE_BITS-1];

    // add-3 adjust on every bcd lane that holds 5 or more, then the whole word shifts left by one
    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            bcd_adj[d] = (bcd_reg[d] >= BCD_ADJ_MIN) ? (bcd_reg[d] + BCD_ADJ) : bcd_reg[d];
        end
    end

    assign pad_eff = ({1'b0, min_digits_reg} > (MIN_DIGITS_W + 1)'(MAX_PAD_DIGITS))
                   ? PAD_W'(MAX_PAD_DIGITS) : PAD_W'(min_digits_reg);

    assign idx_start = (CW'(pad_eff) > CW'(BCD_DIGITS))
                     ? IDX_W'(CW'(pad_eff) - CW'(1)) : IDX_W'(BCD_DIGITS - 1);

    assign cur_digit = (CW'(idx_reg) < CW'(BCD_DIGITS))
                     ? bcd_reg[idx_reg[BCD_IDX_W-1:0]] : 4'd0;

    // leading zero beyond the padded width and not the units digit
    assign skip_zero = (idx_reg != '0) && (cur_digit == 4'd0)
                    && (CW'(idx_reg) >= CW'(pad_eff));

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!skip_zero) begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (out_free && (idx_reg == '0)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath and output register ----------------
    always_comb begin
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        neg_next      = neg_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    bin_next = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;
                    neg_next = in_neg;
                    bcd_next = '0;
                    cnt_next = CNT_W'(VALUE_BITS);
                end
            end
            ST_CONVERT: begin
                bcd_next = (BCD_DIGITS * 4)'({bcd_adj, bin_reg[VALUE_BITS-1]});
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    idx_next = idx_start;
                end
            end
            ST_SCAN: begin
                if (skip_zero) begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    char_next     = CHAR_MINUS;
                    last_next     = 1'b0;
                end
            end
            ST_DIGITS: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    char_next     = CHAR_ZERO + CHAR_W'(cur_digit);
                    last_next     = (idx_reg == '0);
                    if (idx_reg != '0) begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        idx_reg  <= idx_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(char_reg);
    assign m_tlast  = last_reg;

    // ---------------- assertions ----------------
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (char_reg == CHAR_MINUS)
                      || ((char_reg >= CHAR_ZERO) && (char_reg <= CHAR_NINE)))
        else $error("output character outside '-' and '0'..'9'");

    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (char_reg == CHAR_MINUS)) |-> !last_reg)
        else $error("sign character flagged as last");

    a_sign_only_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SIGN) |-> neg_reg)
        else $error("sign emitted for a non-negative value");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_CONVERT) && (cnt_reg == CNT_W'(VALUE_BITS)))
        else $error("conversion did not start after accept");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONVERT) |-> (cnt_reg != '0) && (cnt_reg <= CNT_W'(VALUE_BITS)))
        else $error("conversion counter out of range");

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the signed integer to decimal ascii converter
`timescale 1ns / 1ps

module testbench;
    import sida_pkg::*;

    localparam int VALUE_W       = DEF_VALUE_BITS;
    localparam int PAD_MAX       = DEF_MAX_PAD_DIGITS;
    localparam int S_TDATA_W     = ((VALUE_W + 7) / 8) * 8;
    localparam int REG_IDX_MIN_DIGITS = 0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MIN_DIGITS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 80;
    localparam int RANDOM_PER_PHASE = 27;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } text_char_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr    = '0;
    logic [CFG_DATA_W-1:0]  pwdata   = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    logic [VALUE_W-1:0] pending_values[$];
    text_char_t         expected_chars[$];
    logic [4:0]         min_digits_cfg = '0;
    bit                 no_idle = 1'b0;
    int                 mismatches = 0;
    int                 send_gap = 0;
    int                 stall_left = 0;
    int                 hold_left = 0;
    bit                 hold_done = 1'b0;
    int                 chars_taken = 0;
    int                 quiet_cycles = 0;

    signed_int_to_decimal_ascii_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [5:0] char_code, [7:6] zero
        .m_tlast  (m_tlast),   // last_char
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_idle_len();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // expected characters of one number: sign, zero padding, digits msd first
    task automatic push_decimal_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit_buf [0:31];
        int                 nd;
        int                 width;
        int                 i;
        text_char_t         c;
        mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
        nd = 0;
        do begin
            digit_buf[nd] = 4'(mag % 10);
            nd++;
            mag = mag / 10;
        end while (mag != 0);
        width = (min_digits_cfg > PAD_MAX) ? PAD_MAX : int'(min_digits_cfg);
        if (nd > width) width = nd;
        if (value[VALUE_W-1]) begin
            c.code    = CHAR_MINUS;
            c.is_last = 1'b0;
            expected_chars.push_back(c);
        end
        for (i = width - 1; i >= 0; i--) begin
            c.code    = CHAR_ZERO + ((i < nd) ? CHAR_W'(digit_buf[i]) : '0);
            c.is_last = (i == 0);
            expected_chars.push_back(c);
        end
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr / 4 == REG_IDX_MIN_DIGITS) min_digits_cfg = data[4:0];
    endtask

    // upper data bits are random, only the low five bits matter
    task automatic set_min_digits(input int unsigned md);
        apb_write(ADDR_MIN_DIGITS, ($urandom & ~32'h1f) | (md & 32'h1f));
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (pending_values.size() != 0 || expected_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned r;
        int unsigned nd;
        longint      lim;
        longint      mag;
        logic [VALUE_W-1:0] v;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            v = $urandom;
        end else if (r < 9) begin
            // magnitude of at most a chosen digit count, or at or just below a power of ten
            nd  = $urandom_range(1, 10);
            lim = 1;
            repeat (nd) lim = lim * 10;
            if (r == 8) mag = lim - longint'($urandom_range(0, 1));
            else        mag = longint'($urandom) % lim;
            v = $urandom_range(0, 1) ? VALUE_W'(-mag) : VALUE_W'(mag);
        end else begin
            case ($urandom_range(0, 4))
                0:       v = '0;
                1:       v = 32'd1;
                2:       v = '1;
                3:       v = 32'h7fff_ffff;
                default: v = 32'h8000_0000;
            endcase
        end
        return v;
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                push_decimal_text(pending_values.pop_front());
                send_gap = pick_idle_len();
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_values.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_values[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                chars_taken++;
                stall_left = pick_idle_len();
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && chars_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // checker
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: char_code=%0d last_char=%0b",
                             m_tdata[CHAR_W-1:0], m_tlast);
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata[CHAR_W-1:0] !== want.code || m_tlast !== want.is_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: char_code exp %0d got %0d, last_char exp %0b got %0b",
                                 want.code, m_tdata[CHAR_W-1:0], want.is_last, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int unsigned phase_md [9];
        int          p;
        int          k;
        phase_md = '{0, 16, 31, 17, 5, 10, 1, 20, 0};
        phase_md[8] = $urandom_range(0, 31);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: boundaries at reset width
        pending_values = '{32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'sd10,
                           32'h7fff_ffff, 32'h8000_0000, 32'd1000000000, -32'sd999999999,
                           32'd123456789, 32'd99999, -32'sd100000, 32'h5555_5555,
                           32'haaaa_aaaa};
        wait_drained();
        // widest padding
        set_min_digits(PAD_MAX);
        pending_values = '{32'd0, 32'h8000_0000, 32'd42, -32'sd7, 32'h7fff_ffff};
        wait_drained();
        // width above range saturates
        set_min_digits(17);
        pending_values = '{32'd5, -32'sd5};
        wait_drained();
        set_min_digits(31);
        pending_values = '{32'd0, 32'hffff_ffff};
        wait_drained();
        // write to an unmapped register leaves the width alone
        apb_write(ADDR_UNMAPPED, 32'd3);
        pending_values = '{32'd7};
        wait_drained();
        // width one is smaller than most numbers
        set_min_digits(1);
        pending_values = '{32'd0, 32'd123};
        wait_drained();

        for (p = 0; p < 9; p++) begin
            set_min_digits(phase_md[p]);
            no_idle = (p == 3 || p == 6);
            for (k = 0; k < RANDOM_PER_PHASE; k++)
                pending_values.push_back(random_value());
            wait_drained();
        end
        no_idle = 1'b0;

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
